// File: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk while rst_n is high.
`define LTP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Check prop at every rising edge of clk, reset included.
`define LTP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// File: src/ltp_pkg.sv
// Types, constants and helper functions for the infix to postfix converter.
package ltp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int OP_W        = 2;
  localparam int Q_DEPTH     = 4;
  localparam int QPTR_W      = $clog2(Q_DEPTH);
  localparam int QCNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_OR    = 8'h56;
  localparam logic [7:0] CH_NOT   = 8'h7E;
  localparam logic [7:0] CH_IMP   = 8'h3E;
  localparam logic [7:0] CH_AND   = 8'h5E;

  typedef enum logic [OP_W-1:0] {
    OP_OR  = 2'd0,
    OP_NOT = 2'd1,
    OP_IMP = 2'd2,
    OP_AND = 2'd3
  } op_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_EMIT,
    K_POP,
    K_UNDER,
    K_OVF
  } first_kind_t;

  typedef enum logic [1:0] {
    E_FWD,
    E_RD0,
    E_RD1,
    E_UNDER
  } eof_src_t;

  typedef struct packed {
    first_kind_t kind;
    logic [7:0]  sym;
    logic        eof;
    eof_src_t    esrc;
    op_code_t    fwd;
  } stage_t;

  typedef struct packed {
    logic [7:0] sym;
    status_t    status;
    logic       last;
  } result_t;

  function automatic logic [7:0] op_char(input op_code_t code);
    logic [7:0] c;
    unique case (code)
      OP_OR:   c = CH_OR;
      OP_NOT:  c = CH_NOT;
      OP_IMP:  c = CH_IMP;
      OP_AND:  c = CH_AND;
      default: c = CH_OR;
    endcase
    return c;
  endfunction

  function automatic logic is_op(input logic [7:0] sym);
    return (sym == CH_OR) || (sym == CH_NOT) || (sym == CH_IMP) || (sym == CH_AND);
  endfunction

  function automatic op_code_t op_of(input logic [7:0] sym);
    op_code_t code;
    priority if (sym == CH_NOT) begin
      code = OP_NOT;
    end else if (sym == CH_IMP) begin
      code = OP_IMP;
    end else if (sym == CH_AND) begin
      code = OP_AND;
    end else begin
      code = OP_OR;
    end
    return code;
  endfunction

endpackage

// File: src/ltp_ram.sv
// Generic RAM: one write port, two registered read ports.
module ltp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0 <= mem_r[raddr0];
    rdata1 <= mem_r[raddr1];
  end

endmodule

// File: src/logic_formula_infix_to_postfix_top.sv
// Top level of the infix to postfix converter for parenthesized formulas.
//
//  channel | ports                                          | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid in_ready in_symbol in_end_of_formula  | in
//  out     | out_valid out_ready out_symbol_out out_status   | out
//          | out_last                                       |
//
// One input beat per cycle while in_ready is high; results are staged in s1_r.
// An input beat yields zero, one or two output beats; the output side moves one
// beat per cycle if out_ready is high, so two-result beats limit the input rate.
// The operator stack lives in a RAM with registered reads; its contents need no reset.
// Synchronous reset clears the stack count, the stage valid and the output queue.
// A stalled output fills a four-entry queue; in_ready drops when it may not fit.
module logic_formula_infix_to_postfix_top import ltp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       in_end_of_formula,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol_out,
  output logic [1:0] out_status,
  output logic       out_last
);

  logic             in_fire;
  logic [CNT_W-1:0] count_r, count_nxt, cnt1;
  logic             push;
  first_kind_t      kind;
  eof_src_t         esrc;
  op_code_t         code;

  logic             s1_v_r;
  stage_t           s1_r;
  logic [OP_W-1:0]  rd0, rd1;
  logic [CNT_W-1:0] addr_m1, addr_m2;

  result_t          r0, r1;
  logic             r0_v;
  logic [1:0]       s1_n;

  result_t             q_r [Q_DEPTH];
  logic [QPTR_W-1:0]   head_r, tail_r;
  logic [QCNT_W-1:0]   qcnt_r, qcnt_nxt;
  logic                out_fire;

  assign in_fire  = in_valid && in_ready;
  assign code     = op_of(in_symbol);
  assign addr_m1  = count_r - CNT_W'(1);
  assign addr_m2  = count_r - CNT_W'(2);

  always_comb begin
    cnt1 = count_r;
    push = 1'b0;
    kind = K_NONE;
    priority if (in_symbol == CH_CLOSE) begin
      if (count_r != '0) begin
        kind = K_POP;
        cnt1 = count_r - CNT_W'(1);
      end else begin
        kind = K_UNDER;
      end
    end else if (is_op(in_symbol)) begin
      if (count_r >= CNT_W'(STACK_DEPTH)) begin
        kind = K_OVF;
      end else begin
        push = 1'b1;
        cnt1 = count_r + CNT_W'(1);
      end
    end else if (in_symbol == CH_OPEN) begin
      kind = K_NONE;
    end else begin
      kind = K_EMIT;
    end

    priority if (push) begin
      esrc = E_FWD;
    end else if (cnt1 == '0) begin
      esrc = E_UNDER;
    end else if (kind == K_POP) begin
      esrc = E_RD1;
    end else begin
      esrc = E_RD0;
    end

    if (in_fire) begin
      count_nxt = in_end_of_formula ? '0 : cnt1;
    end else begin
      count_nxt = count_r;
    end
  end

  ltp_ram #(
    .WIDTH (OP_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .we     (in_fire && push),
    .waddr  (count_r[ADDR_W-1:0]),
    .wdata  (code),
    .raddr0 (addr_m1[ADDR_W-1:0]),
    .raddr1 (addr_m2[ADDR_W-1:0]),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      s1_v_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      s1_v_r  <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.kind <= kind;
      s1_r.sym  <= in_symbol;
      s1_r.eof  <= in_end_of_formula;
      s1_r.esrc <= esrc;
      s1_r.fwd  <= code;
    end
  end

  always_comb begin
    r0_v = s1_r.kind != K_NONE;
    unique case (s1_r.kind)
      K_EMIT:  r0 = '{sym: s1_r.sym, status: ST_OK, last: 1'b0};
      K_POP:   r0 = '{sym: op_char(op_code_t'(rd0)), status: ST_OK, last: 1'b0};
      K_UNDER: r0 = '{sym: 8'd0, status: ST_UNDERFLOW, last: 1'b0};
      K_OVF:   r0 = '{sym: 8'd0, status: ST_OVERFLOW, last: 1'b0};
      default: r0 = '{sym: 8'd0, status: ST_OK, last: 1'b0};
    endcase
    unique case (s1_r.esrc)
      E_FWD:   r1 = '{sym: op_char(s1_r.fwd), status: ST_OK, last: 1'b1};
      E_RD0:   r1 = '{sym: op_char(op_code_t'(rd0)), status: ST_OK, last: 1'b1};
      E_RD1:   r1 = '{sym: op_char(op_code_t'(rd1)), status: ST_OK, last: 1'b1};
      default: r1 = '{sym: 8'd0, status: ST_UNDERFLOW, last: 1'b1};
    endcase
    if (s1_v_r) begin
      s1_n = {1'b0, r0_v} + {1'b0, s1_r.eof};
    end else begin
      s1_n = 2'd0;
    end
  end

  assign out_fire  = out_valid && out_ready;
  assign in_ready  = (qcnt_r + QCNT_W'(s1_n)) <= QCNT_W'(Q_DEPTH - 2);
  assign qcnt_nxt  = qcnt_r + QCNT_W'(s1_n) - QCNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      if (r0_v) begin
        q_r[tail_r] <= r0;
        if (s1_r.eof) begin
          q_r[tail_r + QPTR_W'(1)] <= r1;
        end
      end else if (s1_r.eof) begin
        q_r[tail_r] <= r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      qcnt_r <= '0;
    end else begin
      head_r <= head_r + QPTR_W'(out_fire);
      tail_r <= tail_r + QPTR_W'(s1_n);
      qcnt_r <= qcnt_nxt;
    end
  end

  assign out_valid      = qcnt_r != '0;
  assign out_symbol_out = q_r[head_r].sym;
  assign out_status     = q_r[head_r].status;
  assign out_last       = q_r[head_r].last;

endmodule

// File: src/ltp_checker.sv
// Port-level assertions for the infix to postfix converter, bound to the top level.
`include "assert_macros.svh"

module ltp_checker import ltp_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_symbol_out,
  input logic [1:0] out_status,
  input logic       out_last
);

  `LTP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  `LTP_ASSERT(a_status_code, clk, rst_n, out_valid |-> out_status != 2'd3)

  `LTP_ASSERT(a_error_zero, clk, rst_n,
    (out_valid && out_status != ST_OK) |-> out_symbol_out == 8'd0)

  `LTP_ASSERT(a_ovf_not_last, clk, rst_n,
    (out_valid && out_status == ST_OVERFLOW) |-> !out_last)

  `LTP_ASSERT(a_out_hold, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_symbol_out)))

endmodule

bind logic_formula_infix_to_postfix_top ltp_checker u_ltp_checker (.*);
